// ===== src/mlo_pkg.sv =====
// ----------------------------------------------------------------------------
// mlo_pkg
// Shared types, constants and the arctangent table of the mouse-look block.
// ----------------------------------------------------------------------------
package mlo_pkg;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [2:0] REG_SENS   = 3'd0;
  localparam logic [2:0] REG_UPAXIS = 3'd1;
  localparam logic [2:0] REG_POS_X  = 3'd2;
  localparam logic [2:0] REG_POS_Y  = 3'd3;
  localparam logic [2:0] REG_POS_Z  = 3'd4;

  // Up axis codes; any other code selects Z.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Angles in 1/256 degree.
  localparam int PITCH_LIMIT = 22784;
  localparam int YAW_FULL    = 92160;
  localparam int YAW_HALF    = 46080;
  localparam int YAW_QUARTER = 23040;

  // Reciprocal of 45 for the yaw wrap: q = (u * YAW_RECIP) >> YAW_RSHIFT, u < 2^18.
  localparam int YAW_RECIP  = 372828;
  localparam int YAW_RSHIFT = 24;

  localparam int ONE_Q14 = 16384;

  // CORDIC datapath widths: x and y in Q.30 with headroom, z in 2^-16 degree.
  localparam int X_W   = 34;
  localparam int Z_W   = 26;
  localparam int TAB_W = 22;
  localparam int IDX_W = 5;

  localparam logic signed [X_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic               done;
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
  } cordic_res_t;

  // atan(2^-i) in degrees times 65536, rounded to nearest.
  function automatic logic [TAB_W-1:0] atan_tab(input logic [IDX_W-1:0] idx);
    logic [TAB_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/mlo_cordic.sv =====
// ----------------------------------------------------------------------------
// mlo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, giving the
// sine and cosine of an angle within +-90 degrees in Q1.14.
// ----------------------------------------------------------------------------
module mlo_cordic #(
  parameter int STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [15:0]        angle,
  output mlo_pkg::cordic_res_t      res
);

  localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

  logic                              running;
  logic                              done;
  logic [CW-1:0]                     cnt;
  logic signed [mlo_pkg::X_W-1:0]    x;
  logic signed [mlo_pkg::X_W-1:0]    y;
  logic signed [mlo_pkg::Z_W-1:0]    z;

  logic [mlo_pkg::IDX_W-1:0]         sh;
  logic signed [mlo_pkg::X_W-1:0]    dx;
  logic signed [mlo_pkg::X_W-1:0]    dy;
  logic signed [mlo_pkg::Z_W-1:0]    da;
  logic signed [mlo_pkg::X_W-1:0]    xr;
  logic signed [mlo_pkg::X_W-1:0]    yr;

  function automatic logic signed [15:0] clamp_q14(input logic signed [mlo_pkg::X_W-1:0] v);
    logic signed [15:0] r;
    if (v > mlo_pkg::X_W'(mlo_pkg::ONE_Q14)) begin
      r = 16'(mlo_pkg::ONE_Q14);
    end else if (v < -mlo_pkg::X_W'(mlo_pkg::ONE_Q14)) begin
      r = -16'(mlo_pkg::ONE_Q14);
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Shared shifter: both cross terms use the same step index.
  assign sh = mlo_pkg::IDX_W'(cnt);
  assign dx = y >>> sh;
  assign dy = x >>> sh;
  assign da = signed'({{(mlo_pkg::Z_W - mlo_pkg::TAB_W){1'b0}}, mlo_pkg::atan_tab(sh)});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (running) begin
        if (cnt == LAST) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end else if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (running) begin
      if (!z[mlo_pkg::Z_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - da;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + da;
      end
    end else if (start) begin
      x <= mlo_pkg::CORDIC_GAIN;
      y <= '0;
      z <= {{(mlo_pkg::Z_W - 24){angle[15]}}, angle, 8'd0};
    end
  end

  // Round Q.30 to Q1.14: add half an LSB, then floor.
  assign xr = (x + mlo_pkg::X_W'(32768)) >>> 16;
  assign yr = (y + mlo_pkg::X_W'(32768)) >>> 16;

  assign res.done  = done;
  assign res.cos_v = clamp_q14(xr);
  assign res.sin_v = clamp_q14(yr);

endmodule

// ===== src/mouse_look_orientation.sv =====
// ----------------------------------------------------------------------------
// mouse_look_orientation
// First-person camera look: mouse motion updates pitch and yaw, and the block
// returns view direction, lateral vector and target point in Q1.14 / Q.14.
// A single CORDIC unit runs pitch and then yaw, one micro-rotation per cycle;
// a new input beat is taken only while the sequencer is idle.
// A finished result waits in the output register while the next item starts.
// Synchronous reset: angles to zero, sensitivity 0, up axis Z, position 0.
// ----------------------------------------------------------------------------
module mouse_look_orientation #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // delta_x[11:0], delta_y[23:12]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,   // dir_x, dir_y, dir_z, side_x, side_y, side_z
                                  // (16 bits each), target_x, target_y, target_z
                                  // (32 bits each)
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MULP  = 4'd1;
  localparam logic [3:0] ST_PITCH = 4'd2;
  localparam logic [3:0] ST_YSUM  = 4'd3;
  localparam logic [3:0] ST_RECIP = 4'd4;
  localparam logic [3:0] ST_YMOD  = 4'd5;
  localparam logic [3:0] ST_CPW   = 4'd6;
  localparam logic [3:0] ST_CYW   = 4'd7;
  localparam logic [3:0] ST_MULC  = 4'd8;
  localparam logic [3:0] ST_MULS  = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  logic [3:0]          state;
  logic [3:0]          state_next;

  logic [15:0]         sensitivity;
  logic [1:0]          up_axis;
  logic signed [31:0]  pos_x;
  logic signed [31:0]  pos_y;
  logic signed [31:0]  pos_z;

  logic signed [15:0]  pitch_angle;
  logic [16:0]         yaw_angle;

  logic signed [11:0]  delta_x;
  logic signed [11:0]  delta_y;

  logic signed [19:0]  mul_a;
  logic signed [19:0]  mul_b;
  logic signed [39:0]  prod;

  logic signed [30:0]  psum;
  logic signed [30:0]  vsum;
  logic signed [19:0]  vshift;
  logic [20:0]         u_wide;
  logic [17:0]         u_val;
  logic [12:0]         quot;
  logic [18:0]         q45;
  logic [18:0]         rem;

  logic signed [17:0]  ya_wrap;
  logic signed [17:0]  ya_red;
  logic                ya_flip;
  logic                flip;

  logic signed [15:0]  sp;
  logic signed [15:0]  cp;
  logic signed [15:0]  sy;
  logic signed [15:0]  cy;
  logic signed [15:0]  cpcy;
  logic signed [39:0]  prod_rnd;

  logic                cor_start;
  logic signed [15:0]  cor_angle;
  mlo_pkg::cordic_res_t cor_res;

  logic signed [15:0]  dir_x;
  logic signed [15:0]  dir_y;
  logic signed [15:0]  dir_z;
  logic signed [15:0]  side_x;
  logic signed [15:0]  side_y;
  logic signed [15:0]  side_z;
  logic signed [15:0]  cpsy;

  logic                cfg_wr;

  function automatic logic [31:0] sat_add(input logic signed [31:0] a,
                                          input logic signed [15:0] b);
    logic signed [32:0] s;
    logic [31:0]        r;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity <= '0;
      up_axis     <= mlo_pkg::AXIS_Z;
      pos_x       <= '0;
      pos_y       <= '0;
      pos_z       <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        mlo_pkg::REG_SENS:   sensitivity <= pwdata[15:0];
        mlo_pkg::REG_UPAXIS: up_axis     <= pwdata[1:0];
        mlo_pkg::REG_POS_X:  pos_x       <= pwdata;
        mlo_pkg::REG_POS_Y:  pos_y       <= pwdata;
        mlo_pkg::REG_POS_Z:  pos_z       <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      mlo_pkg::REG_SENS:   prdata = {16'd0, sensitivity};
      mlo_pkg::REG_UPAXIS: prdata = {30'd0, up_axis};
      mlo_pkg::REG_POS_X:  prdata = pos_x;
      mlo_pkg::REG_POS_Y:  prdata = pos_y;
      mlo_pkg::REG_POS_Z:  prdata = pos_z;
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_MULP;
      ST_MULP:  state_next = ST_PITCH;
      ST_PITCH: state_next = ST_YSUM;
      ST_YSUM:  state_next = ST_RECIP;
      ST_RECIP: state_next = ST_YMOD;
      ST_YMOD:  state_next = ST_CPW;
      ST_CPW:   if (cor_res.done) state_next = ST_CYW;
      ST_CYW:   if (cor_res.done) state_next = ST_MULC;
      ST_MULC:  state_next = ST_MULS;
      ST_MULS:  state_next = ST_OUT;
      ST_OUT:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Shared multiplier; each product is read in the state right after it.
  // The cos(pitch)*sin(yaw) product is kept alive while the result waits.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MULP: begin
        mul_a = 20'(delta_y);
        mul_b = signed'({4'd0, sensitivity});
      end
      ST_PITCH: begin
        mul_a = 20'(delta_x);
        mul_b = signed'({4'd0, sensitivity});
      end
      ST_RECIP: begin
        mul_a = signed'({2'd0, u_val});
        mul_b = 20'(mlo_pkg::YAW_RECIP);
      end
      ST_MULC: begin
        mul_a = 20'(cp);
        mul_b = 20'(cy);
      end
      ST_MULS, ST_OUT: begin
        mul_a = 20'(cp);
        mul_b = 20'(sy);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Pitch: subtract the scaled motion and clamp to +-89 degrees.
  assign psum = 31'(pitch_angle) - prod[30:0];

  // Yaw wrap modulo 92160 = 2048 * 45: the low 11 bits pass, the rest is
  // reduced modulo 45 with a reciprocal multiply and one constant product.
  assign vshift = 20'(vsum >>> 11);
  assign u_wide = 21'(vshift) + 21'(mlo_pkg::YAW_FULL);
  assign u_val  = u_wide[17:0];
  assign quot   = prod[mlo_pkg::YAW_RSHIFT+12:mlo_pkg::YAW_RSHIFT];
  assign q45    = {1'b0, quot, 5'd0} + {3'd0, quot, 3'd0} + {4'd0, quot, 2'd0}
                + {6'd0, quot};
  assign rem    = {1'b0, u_val} - q45;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_angle <= '0;
      yaw_angle   <= '0;
    end else begin
      if (state == ST_PITCH) begin
        if (psum > 31'(mlo_pkg::PITCH_LIMIT)) begin
          pitch_angle <= 16'(mlo_pkg::PITCH_LIMIT);
        end else if (psum < -31'(mlo_pkg::PITCH_LIMIT)) begin
          pitch_angle <= -16'(mlo_pkg::PITCH_LIMIT);
        end else begin
          pitch_angle <= psum[15:0];
        end
      end
      if (state == ST_YMOD) begin
        yaw_angle <= {rem[5:0], vsum[10:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      delta_x <= s_tdata[11:0];
      delta_y <= s_tdata[23:12];
    end
    if (state == ST_YSUM) begin
      vsum <= signed'({14'd0, yaw_angle}) - prod[30:0];
    end
  end

  // Yaw into -90..90 degrees; beyond a quarter turn the half turn is folded
  // away and both sine and cosine change sign.
  always_comb begin
    if (yaw_angle >= 17'(mlo_pkg::YAW_HALF)) begin
      ya_wrap = signed'({1'b0, yaw_angle}) - 18'(mlo_pkg::YAW_FULL);
    end else begin
      ya_wrap = signed'({1'b0, yaw_angle});
    end
    ya_flip = 1'b0;
    ya_red  = ya_wrap;
    if (ya_wrap > 18'(mlo_pkg::YAW_QUARTER)) begin
      ya_red  = ya_wrap - 18'(mlo_pkg::YAW_HALF);
      ya_flip = 1'b1;
    end else if (ya_wrap < -18'(mlo_pkg::YAW_QUARTER)) begin
      ya_red  = ya_wrap + 18'(mlo_pkg::YAW_HALF);
      ya_flip = 1'b1;
    end
  end

  always_comb begin
    cor_start = 1'b0;
    cor_angle = pitch_angle;
    if (state == ST_YMOD) begin
      cor_start = 1'b1;
    end else if (state == ST_CPW && cor_res.done) begin
      cor_start = 1'b1;
      cor_angle = ya_red[15:0];
    end
  end

  mlo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .res   (cor_res)
  );

  always_ff @(posedge clk) begin
    if (state == ST_CPW && cor_res.done) begin
      sp   <= cor_res.sin_v;
      cp   <= cor_res.cos_v;
      flip <= ya_flip;
    end
    if (state == ST_CYW && cor_res.done) begin
      sy <= flip ? -cor_res.sin_v : cor_res.sin_v;
      cy <= flip ? -cor_res.cos_v : cor_res.cos_v;
    end
    if (state == ST_MULS) begin
      cpcy <= prod_rnd[29:14];
    end
  end

  // Q1.14 product rounding: add half an LSB, then floor.
  assign prod_rnd = prod + 40'sd8192;
  assign cpsy     = prod_rnd[29:14];

  always_comb begin
    case (up_axis)
      mlo_pkg::AXIS_X: begin
        dir_x  = sp;     dir_y  = cpcy;   dir_z  = cpsy;
        side_x = '0;     side_y = -sy;    side_z = cy;
      end
      mlo_pkg::AXIS_Y: begin
        dir_x  = cpsy;   dir_y  = sp;     dir_z  = cpcy;
        side_x = cy;     side_y = '0;     side_z = -sy;
      end
      default: begin
        dir_x  = cpcy;   dir_y  = cpsy;   dir_z  = sp;
        side_x = -sy;    side_y = cy;     side_z = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {sat_add(pos_z, dir_z), sat_add(pos_y, dir_y), sat_add(pos_x, dir_x),
                  side_z, side_y, side_x, dir_z, dir_y, dir_x};
    end
  end

endmodule
